// ===== rtl/clts_pkg.sv =====
`default_nettype none
package clts_pkg;

  // Request codes
  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_COMMAND = 3'd1;
  localparam logic [2:0] CMD_CHAR    = 3'd2;
  localparam logic [2:0] CMD_CHAR_AT = 3'd3;
  localparam logic [2:0] CMD_GLYPH   = 3'd4;

  // Wait codes
  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_20MS  = 2'd1;
  localparam logic [1:0] WAIT_5MS   = 2'd2;
  localparam logic [1:0] WAIT_150US = 2'd3;

  // DDRAM row base addresses (set-address command included)
  localparam logic [7:0] ROW_BASE_1 = 8'h80;
  localparam logic [7:0] ROW_BASE_2 = 8'hC0;
  localparam logic [7:0] ROW_BASE_3 = 8'h94;
  localparam logic [7:0] ROW_BASE_4 = 8'hD4;

  localparam logic [7:0] LCD_FUNC_8BIT = 8'h38;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_HOME      = 8'h02;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
  localparam logic [7:0] LCD_FUNC_4BIT = 8'h28;
  localparam logic [7:0] LCD_CGRAM     = 8'h40;
  localparam logic [7:0] LCD_DDRAM_0   = 8'h80;

  // Step numbers within a request
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_INIT_MODE    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_INIT_LAST    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_GLYPH_CURSOR = 4'd9;
  localparam logic [STEP_W-1:0] STEP_GLYPH_LAST   = 4'd10;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  value;
    logic [2:0]  row;
    logic [5:0]  column;
    logic [63:0] glyph;
    logic [3:0]  slot;
  } job_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic [1:0] wait_code;
    logic       last_byte;
  } xfer_t;

  function automatic logic row_valid(input logic [2:0] row);
    return (row >= 3'd1) && (row <= 3'd4);
  endfunction

  // Row base minus one, so the column (counted from 1) adds in directly
  function automatic logic [7:0] row_base_m1(input logic [2:0] row);
    logic [7:0] base;
    case (row)
      3'd1:    base = ROW_BASE_1;
      3'd2:    base = ROW_BASE_2;
      3'd3:    base = ROW_BASE_3;
      3'd4:    base = ROW_BASE_4;
      default: base = 8'd1;
    endcase
    return base - 8'd1;
  endfunction

  function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step);
    logic [7:0] b;
    case (step)
      4'd0, 4'd1, 4'd2: b = LCD_FUNC_8BIT;
      4'd3:    b = LCD_CLEAR;
      4'd4:    b = LCD_HOME;
      4'd5:    b = LCD_ENTRY;
      4'd6:    b = LCD_DISP_ON;
      4'd7:    b = LCD_FUNC_4BIT;
      default: b = LCD_DDRAM_0;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] init_wait(input logic [STEP_W-1:0] step);
    logic [1:0] w;
    case (step)
      4'd0:    w = WAIT_20MS;
      4'd1:    w = WAIT_5MS;
      4'd2:    w = WAIT_150US;
      default: w = WAIT_NONE;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/char_lcd_transfer_sequencer.sv =====
`default_nettype none
// Character LCD transfer sequencer.
// Input channel (in_valid_i / in_stall_o) takes one request transaction:
// init, raw command, character, character at row/column, or custom glyph.
// Output channel (out_valid_o / out_stall_i) hands out one bus transfer per
// transaction: register select, bus value, wait code, last mark.
// Config: APB-style port, one register at address 0: nibble_mode (bit 0).
// Timing: a taken request sets the run state, and from then on the
// sequencer loads one transfer per cycle into the output register while
// the receiver does not stall; a glyph in four-bit mode is the longest
// request. The next request is taken in the cycle after the final
// transfer is loaded.
// A sequencer steps through the request's bytes and feeds each through one
// shared byte unit; in four-bit mode each byte goes out as two transfers
// (high nibble, then low). in_stall_o is high from acceptance until the
// final transfer is loaded into the output register. Unknown requests are
// taken and produce nothing.
// A stall on the output holds the output register and freezes the sequencer.
// Reset: nibble_mode = 1, sequencer idle, output empty.
module char_lcd_transfer_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output var  logic        in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [7:0]  value_i,
  input  wire logic [2:0]  row_i,
  input  wire logic [5:0]  column_i,
  input  wire logic [63:0] glyph_i,
  input  wire logic [3:0]  slot_i,
  // transfer channel
  output var  logic        out_valid_o,
  input  wire logic        out_stall_i,
  output var  logic        reg_select_o,
  output var  logic [7:0]  bus_value_o,
  output var  logic [1:0]  wait_before_o,
  output var  logic        last_o,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output var  logic [31:0] prdata,
  output var  logic        pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic [clts_pkg::STEP_W-1:0] step_q, step_d, step_nxt;
  logic half_q, half_d;
  logic nib_q;
  clts_pkg::job_t  job_q;
  clts_pkg::xfer_t xfer;

  logic in_acc, emit, advance, emit_last;
  logic [7:0] bus_d;
  logic [1:0] wait_d;
  logic       cmd_known;

  // ---------------- config ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, nib_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      nib_q <= pwdata[0];
    end
  end

  // ---------------- request capture ----------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cmd_known  = (cmd_i <= clts_pkg::CMD_GLYPH);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      job_q <= '{cmd: cmd_i, value: value_i, row: row_i, column: column_i,
                 glyph: glyph_i, slot: slot_i};
    end
  end

  // ---------------- shared byte unit ----------------
  clts_byte_unit u_byte (
    .job_i  (job_q),
    .step_i (step_q),
    .xfer_o (xfer)
  );

  // ---------------- sequencer ----------------
  assign emit      = (state_q == ST_RUN) && (!out_valid_o || !out_stall_i);
  assign advance   = emit && (!nib_q || half_q);
  assign emit_last = advance && xfer.last_byte;

  always_comb begin
    // next step, skipping the four-bit function set in eight-bit mode and
    // the cursor command of a glyph when the row is out of range
    step_nxt = step_q + 4'd1;
    if (job_q.cmd == clts_pkg::CMD_INIT && step_nxt == clts_pkg::STEP_INIT_MODE
        && !nib_q) begin
      step_nxt = clts_pkg::STEP_INIT_LAST;
    end
    if (job_q.cmd == clts_pkg::CMD_GLYPH && step_nxt == clts_pkg::STEP_GLYPH_CURSOR
        && !clts_pkg::row_valid(job_q.row)) begin
      step_nxt = clts_pkg::STEP_GLYPH_LAST;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    half_d  = half_q;
    if (in_acc) begin
      state_d = cmd_known ? ST_RUN : ST_IDLE;
      half_d  = 1'b0;
      // character at position with a bad row starts at the character
      step_d  = (cmd_i == clts_pkg::CMD_CHAR_AT && !clts_pkg::row_valid(row_i))
                ? 4'd1 : 4'd0;
    end else if (emit) begin
      half_d = nib_q && !half_q;
      if (advance) begin
        step_d = step_nxt;
      end
      if (emit_last) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      half_q  <= half_d;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    if (!nib_q) begin
      bus_d  = xfer.data;
      wait_d = xfer.wait_code;
    end else if (!half_q) begin
      bus_d  = {4'd0, xfer.data[7:4]};
      wait_d = xfer.wait_code;
    end else begin
      bus_d  = {4'd0, xfer.data[3:0]};
      wait_d = clts_pkg::WAIT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      reg_select_o  <= xfer.rs;
      bus_value_o   <= bus_d;
      wait_before_o <= wait_d;
      last_o        <= emit_last;
    end
  end

  // ---------------- assertions ----------------
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= clts_pkg::STEP_GLYPH_LAST))
    else $error("step counter out of range");

  a_out_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RUN))
    else $error("transfer produced while idle");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last |=> (state_q == ST_IDLE) && last_o && out_valid_o)
    else $error("final transfer did not end the request");

  a_nibble_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && nib_q) |=> (bus_value_o[7:4] == 4'd0))
    else $error("nibble transfer with upper bits set");

endmodule
`default_nettype wire

// ===== rtl/clts_byte_unit.sv =====
`default_nettype none
// Produces the byte for one step of a request through a single shared
// 8-bit adder (cursor address, CGRAM address, slot position, pass-through).
module clts_byte_unit (
  input  var clts_pkg::job_t                      job_i,
  input  wire logic [clts_pkg::STEP_W-1:0]        step_i,
  output var clts_pkg::xfer_t                     xfer_o
);

  logic [7:0] add_a;
  logic [7:0] add_b;
  logic [2:0] gsel;

  assign gsel = 3'(step_i - 4'd1);

  always_comb begin
    add_a            = 8'd0;
    add_b            = 8'd0;
    xfer_o.rs        = 1'b0;
    xfer_o.wait_code = clts_pkg::WAIT_NONE;
    xfer_o.last_byte = 1'b0;
    case (job_i.cmd)
      clts_pkg::CMD_INIT: begin
        add_a            = clts_pkg::init_byte(step_i);
        xfer_o.wait_code = clts_pkg::init_wait(step_i);
        xfer_o.last_byte = (step_i == clts_pkg::STEP_INIT_LAST);
      end
      clts_pkg::CMD_COMMAND: begin
        add_a            = job_i.value;
        xfer_o.last_byte = 1'b1;
      end
      clts_pkg::CMD_CHAR: begin
        add_a            = job_i.value;
        xfer_o.rs        = 1'b1;
        xfer_o.last_byte = 1'b1;
      end
      clts_pkg::CMD_CHAR_AT: begin
        if (step_i == 4'd0) begin
          add_a = clts_pkg::row_base_m1(job_i.row);
          add_b = {2'b00, job_i.column};
        end else begin
          add_a            = job_i.value;
          xfer_o.rs        = 1'b1;
          xfer_o.last_byte = 1'b1;
        end
      end
      clts_pkg::CMD_GLYPH: begin
        if (step_i == 4'd0) begin
          // 0x40 + 8*(slot-1)
          add_a = clts_pkg::LCD_CGRAM - 8'd8;
          add_b = {1'b0, job_i.slot, 3'b000};
        end else if (step_i < clts_pkg::STEP_GLYPH_CURSOR) begin
          add_a     = job_i.glyph[{gsel, 3'b000} +: 8];
          xfer_o.rs = 1'b1;
        end else if (step_i == clts_pkg::STEP_GLYPH_CURSOR) begin
          add_a = clts_pkg::row_base_m1(job_i.row);
          add_b = {2'b00, job_i.column};
        end else begin
          // slot - 1, wrapping in 8 bits
          add_a            = 8'hFF;
          add_b            = {4'b0000, job_i.slot};
          xfer_o.rs        = 1'b1;
          xfer_o.last_byte = 1'b1;
        end
      end
      default: begin
        xfer_o.last_byte = 1'b1;
      end
    endcase
    xfer_o.data = add_a + add_b;
  end

endmodule
`default_nettype wire

// ===== tb/lcd_transfer_checker.sv =====
`timescale 1ns / 1ps
// Watches the request, transfer and config channels of the LCD transfer
// sequencer, expands every accepted request into the bus transfers it
// should cause and compares them in order against what comes out.
module lcd_transfer_checker #(
  parameter logic [2:0] MODE_ADDR = 3'd0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [7:0]  value_i,
  input  wire logic [2:0]  row_i,
  input  wire logic [5:0]  column_i,
  input  wire logic [63:0] glyph_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic        reg_select_i,
  input  wire logic [7:0]  bus_value_i,
  input  wire logic [1:0]  wait_before_i,
  input  wire logic        last_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic        pready_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output int               fail_count_o,
  output int               pending_o
);

  clts_pkg::xfer_t expected_transfers[$];
  logic  four_bit_bus;
  int    fails;

  // One byte on the bus: one transfer, or high then low nibble.
  function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                     input logic [1:0] code);
    clts_pkg::xfer_t t;
    t.rs        = rs;
    t.last_byte = 1'b0;
    if (four_bit_bus) begin
      t.data      = {4'h0, b[7:4]};
      t.wait_code = code;
      expected_transfers.push_back(t);
      t.data      = {4'h0, b[3:0]};
      t.wait_code = clts_pkg::WAIT_NONE;
      expected_transfers.push_back(t);
    end else begin
      t.data      = b;
      t.wait_code = code;
      expected_transfers.push_back(t);
    end
  endfunction

  // Set-DDRAM-address command; rows outside 1..4 send nothing.
  function automatic void queue_cursor(input logic [2:0] row, input logic [5:0] column);
    logic [7:0] base;
    case (row)
      3'd1:    base = clts_pkg::ROW_BASE_1;
      3'd2:    base = clts_pkg::ROW_BASE_2;
      3'd3:    base = clts_pkg::ROW_BASE_3;
      3'd4:    base = clts_pkg::ROW_BASE_4;
      default: return;
    endcase
    queue_byte(1'b0, base + {2'b00, column} - 8'd1, clts_pkg::WAIT_NONE);
  endfunction

  function automatic void predict_transfers(input logic [2:0] cmd, input logic [7:0] value,
                                            input logic [2:0] row, input logic [5:0] column,
                                            input logic [63:0] glyph, input logic [3:0] slot);
    int              start_size;
    int              i;
    logic [7:0]      pos;
    clts_pkg::xfer_t t;
    start_size = expected_transfers.size();
    pos        = {4'h0, slot} - 8'd1;
    case (cmd)
      clts_pkg::CMD_INIT: begin
        queue_byte(1'b0, clts_pkg::LCD_FUNC_8BIT, clts_pkg::WAIT_20MS);
        queue_byte(1'b0, clts_pkg::LCD_FUNC_8BIT, clts_pkg::WAIT_5MS);
        queue_byte(1'b0, clts_pkg::LCD_FUNC_8BIT, clts_pkg::WAIT_150US);
        queue_byte(1'b0, clts_pkg::LCD_CLEAR, clts_pkg::WAIT_NONE);
        queue_byte(1'b0, clts_pkg::LCD_HOME, clts_pkg::WAIT_NONE);
        queue_byte(1'b0, clts_pkg::LCD_ENTRY, clts_pkg::WAIT_NONE);
        queue_byte(1'b0, clts_pkg::LCD_DISP_ON, clts_pkg::WAIT_NONE);
        if (four_bit_bus) queue_byte(1'b0, clts_pkg::LCD_FUNC_4BIT, clts_pkg::WAIT_NONE);
        queue_byte(1'b0, clts_pkg::LCD_DDRAM_0, clts_pkg::WAIT_NONE);
      end
      clts_pkg::CMD_COMMAND: queue_byte(1'b0, value, clts_pkg::WAIT_NONE);
      clts_pkg::CMD_CHAR:    queue_byte(1'b1, value, clts_pkg::WAIT_NONE);
      clts_pkg::CMD_CHAR_AT: begin
        queue_cursor(row, column);
        queue_byte(1'b1, value, clts_pkg::WAIT_NONE);
      end
      clts_pkg::CMD_GLYPH: begin
        // CGRAM address wraps in 8 bits: 8*pos keeps only pos[4:0]
        queue_byte(1'b0, clts_pkg::LCD_CGRAM + {pos[4:0], 3'b000}, clts_pkg::WAIT_NONE);
        for (i = 0; i < 8; i++) queue_byte(1'b1, glyph[8*i +: 8], clts_pkg::WAIT_NONE);
        queue_cursor(row, column);
        queue_byte(1'b1, pos, clts_pkg::WAIT_NONE);
      end
      default: ;
    endcase
    if (expected_transfers.size() > start_size) begin
      t = expected_transfers.pop_back();
      t.last_byte = 1'b1;
      expected_transfers.push_back(t);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    clts_pkg::xfer_t want;
    if (!rst_ni) begin
      expected_transfers.delete();
      four_bit_bus = 1'b1;
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == MODE_ADDR)
        four_bit_bus = pwdata_i[0];

      if (out_valid_i && !out_stall_i) begin
        if (expected_transfers.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected transfer rs=%0d bus=%02h wait=%0d last=%0d",
                     $realtime, reg_select_i, bus_value_i, wait_before_i, last_i);
        end else begin
          want = expected_transfers.pop_front();
          if (reg_select_i !== want.rs || bus_value_i !== want.data ||
              wait_before_i !== want.wait_code || last_i !== want.last_byte) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: transfer mismatch exp rs=%0d bus=%02h wait=%0d last=%0d",
                        " got rs=%0d bus=%02h wait=%0d last=%0d"},
                       $realtime, want.rs, want.data, want.wait_code, want.last_byte,
                       reg_select_i, bus_value_i, wait_before_i, last_i);
          end
        end
      end

      if (in_valid_i && !in_stall_i)
        predict_transfers(cmd_i, value_i, row_i, column_i, glyph_i, slot_i);

      fail_count_o <= fails;
      pending_o    <= expected_transfers.size();
    end
  end

endmodule

// ===== tb/tb_char_lcd_transfer_sequencer.sv =====
`timescale 1ns / 1ps
// Top of the sequencer bench: clock, reset, request stimulus, receiver
// stalls and config writes. Checking lives in lcd_transfer_checker.
module tb_char_lcd_transfer_sequencer;

  // Config map: nibble_mode at word 0; word 1 is unmapped and must be ignored
  localparam logic [2:0] ADDR_NIBBLE_MODE = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

  // Request codes with no meaning; the block takes them and sends nothing
  localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 30;   // longer than the longest request, plus slack
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int RANDOM_PER_PHASE = 45;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [7:0]  value;
  logic [2:0]  row;
  logic [5:0]  column;
  logic [63:0] glyph;
  logic [3:0]  slot;
  logic        out_valid;
  logic        out_stall;
  logic        reg_select;
  logic [7:0]  bus_value;
  logic [1:0]  wait_before;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_off;
  bit   hold_go;
  int   fail_count;
  int   pending;
  int   cycles;

  char_lcd_transfer_sequencer uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .value_i       (value),
    .row_i         (row),
    .column_i      (column),
    .glyph_i       (glyph),
    .slot_i        (slot),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .reg_select_o  (reg_select),
    .bus_value_o   (bus_value),
    .wait_before_o (wait_before),
    .last_o        (last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lcd_transfer_checker #(.MODE_ADDR(ADDR_NIBBLE_MODE)) transfer_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .cmd_i         (cmd),
    .value_i       (value),
    .row_i         (row),
    .column_i      (column),
    .glyph_i       (glyph),
    .slot_i        (slot),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .reg_select_i  (reg_select),
    .bus_value_i   (bus_value),
    .wait_before_i (wait_before),
    .last_i        (last),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: ends the run if the transfers never drain.
  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls, forced high during the hold-off window.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off; the sender keeps offering, so the block backs
  // up and has to stall its request channel.
  initial begin
    hold_off <= 1'b0;
    wait (hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // One request transaction: optional idle gap, then hold until taken.
  task automatic send_request(input logic [2:0] c, input logic [7:0] v,
                              input logic [2:0] r, input logic [5:0] col,
                              input logic [63:0] g, input logic [3:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    row      <= r;
    column   <= col;
    glyph    <= g;
    slot     <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly legal rows, columns and slots; the rest anywhere in the field.
  task automatic send_random();
    int         pick;
    logic [2:0] c;
    logic [2:0] r;
    logic [5:0] col;
    logic [3:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 8)       c = clts_pkg::CMD_INIT;
    else if (pick < 25) c = clts_pkg::CMD_COMMAND;
    else if (pick < 45) c = clts_pkg::CMD_CHAR;
    else if (pick < 70) c = clts_pkg::CMD_CHAR_AT;
    else if (pick < 92) c = clts_pkg::CMD_GLYPH;
    else                c = 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
    r   = 3'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)  : $urandom_range(0, 7));
    col = 6'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 40) : $urandom_range(0, 63));
    s   = 4'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)  : $urandom_range(0, 15));
    send_request(c, 8'($urandom_range(0, 255)), r, col, {$urandom, $urandom}, s);
  endtask

  // Drop valid, let every expected transfer arrive, then allow the block
  // to finish any request that produces nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper data bits are random: only bit 0 may matter.
  task automatic set_bus_mode(input logic four_bit);
    settle();
    apb_write(ADDR_NIBBLE_MODE, ($urandom & 32'hFFFF_FFFE) | {31'd0, four_bit});
  endtask

  initial begin : stimulus
    int         i;
    logic [2:0] c;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    cmd      <= clts_pkg::CMD_INIT;
    value    <= 8'h00;
    row      <= 3'd0;
    column   <= 6'd0;
    glyph    <= 64'd0;
    slot     <= 4'd0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= ADDR_NIBBLE_MODE;
    pwdata   <= 32'd0;
    hold_go       = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 85;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, four-bit bus (reset value) ---
    send_request(clts_pkg::CMD_INIT,    8'h00, 3'd0, 6'd0,  64'd0, 4'd0);
    send_request(clts_pkg::CMD_COMMAND, 8'h00, 3'd0, 6'd0,  64'd0, 4'd0);
    send_request(clts_pkg::CMD_COMMAND, 8'hFF, 3'd7, 6'd63, 64'd0, 4'd15);
    send_request(clts_pkg::CMD_CHAR,    8'h5A, 3'd1, 6'd1,  64'd0, 4'd1);
    send_request(clts_pkg::CMD_CHAR_AT, 8'h41, 3'd1, 6'd1,  64'd0, 4'd1);
    send_request(clts_pkg::CMD_CHAR_AT, 8'hFF, 3'd2, 6'd40, 64'd0, 4'd1);
    // column zero: address falls one below the row base
    send_request(clts_pkg::CMD_CHAR_AT, 8'h00, 3'd3, 6'd0,  64'd0, 4'd1);
    send_request(clts_pkg::CMD_CHAR_AT, 8'h7E, 3'd4, 6'd63, 64'd0, 4'd1);
    // rows outside 1..4: no cursor command, character still goes out
    send_request(clts_pkg::CMD_CHAR_AT, 8'h30, 3'd0, 6'd5,  64'd0, 4'd1);
    send_request(clts_pkg::CMD_CHAR_AT, 8'h31, 3'd7, 6'd5,  64'd0, 4'd1);
    send_request(clts_pkg::CMD_CHAR_AT, 8'h32, 3'd5, 6'd12, 64'd0, 4'd1);
    send_request(clts_pkg::CMD_GLYPH,   8'h00, 3'd1, 6'd1,  64'd0, 4'd1);
    send_request(clts_pkg::CMD_GLYPH,   8'h00, 3'd4, 6'd40, {64{1'b1}}, 4'd8);
    // slot zero wraps to 0xFF; slot 15 spills past the eight CGRAM slots
    send_request(clts_pkg::CMD_GLYPH,   8'h00, 3'd0, 6'd3,  64'h0123_4567_89AB_CDEF, 4'd0);
    send_request(clts_pkg::CMD_GLYPH,   8'h00, 3'd2, 6'd63, {$urandom, $urandom}, 4'd15);
    for (c = CMD_RESERVED_FIRST; c != CMD_RESERVED_LAST; c++)
      send_request(c, 8'hFF, 3'd1, 6'd1, {64{1'b1}}, 4'd1);
    send_request(CMD_RESERVED_LAST, 8'hFF, 3'd1, 6'd1, {64{1'b1}}, 4'd1);

    // write to an unmapped word must leave the bus in four-bit mode
    settle();
    apb_write(ADDR_UNMAPPED, 32'd0);
    send_request(clts_pkg::CMD_CHAR, 8'hC3, 3'd1, 6'd1, 64'd0, 4'd1);

    // --- directed, eight-bit bus ---
    set_bus_mode(1'b0);
    send_request(clts_pkg::CMD_INIT,    8'h00, 3'd0, 6'd0,  64'd0, 4'd0);
    send_request(clts_pkg::CMD_GLYPH,   8'h00, 3'd3, 6'd7,  {$urandom, $urandom}, 4'd3);
    send_request(clts_pkg::CMD_CHAR_AT, 8'h55, 3'd6, 6'd2,  64'd0, 4'd1);
    send_request(clts_pkg::CMD_COMMAND, 8'h80, 3'd0, 6'd0,  64'd0, 4'd0);
    send_request(clts_pkg::CMD_CHAR,    8'hFF, 3'd0, 6'd0,  64'd0, 4'd0);

    // --- random: slow receiver, eight-bit bus ---
    for (i = 0; i < RANDOM_PER_PHASE; i++) send_random();

    // --- random: slow sender, four-bit bus ---
    set_bus_mode(1'b1);
    send_idle_pct = 85;
    recv_idle_pct = 35;
    for (i = 0; i < RANDOM_PER_PHASE; i++) send_random();

    // --- random: back to back, with the long receiver hold-off ---
    set_bus_mode(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    for (i = 0; i < RANDOM_PER_PHASE / 2; i++) send_random();
    set_bus_mode(1'b1);
    for (i = RANDOM_PER_PHASE / 2; i < RANDOM_PER_PHASE; i++) send_random();

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
